[rtl/emts_pkg.sv]
// shared types and constants for the event move two point solver
package emts_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int EPS_W = 25;
    localparam logic [EPS_W-1:0] EPS_RESET = 25'd17;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD_T   = 3'd1,
        ST_EQUAL_T = 3'd2,
        ST_UNIDENT = 3'd3,
        ST_NEG     = 3'd4,
        ST_SAT     = 3'd5
    } status_t;

    typedef struct packed {
        logic signed [31:0] variance_one;
        logic signed [31:0] time_one;
        logic [7:0]         count_one;
        logic signed [31:0] variance_two;
        logic signed [31:0] time_two;
        logic [7:0]         count_two;
    } in_item_t;

    typedef struct packed {
        logic [31:0] event_move;
        status_t     status;
    } out_item_t;

endpackage

[rtl/event_move_two_point_solver.sv]
// top level of the event move two point solver
//
//  channel | direction | handshake       | payload
//  in      | into      | in_valid/stall  | in_item (emts_pkg::in_item_t)
//  out     | out of    | out_valid/stall | out_item (emts_pkg::out_item_t)
//  config  | into      | cfg_we          | cfg_data, clamp epsilon
//
// one transfer per cycle in each direction while the output register is empty or
// out_stall is low; results pass through the front, divider, range check, root and
// output registers, the divider and root taking one bit per stage
// the whole pipeline advances together; an output register holds the head result
// and in_stall is raised only when that register is full and out_stall is high
// reset clears valid bits and sets clamp epsilon to 17
module event_move_two_point_solver #(
    parameter int FRAC_BITS = emts_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  emts_pkg::in_item_t          in_item,
    output logic                        out_valid,
    input  logic                        out_stall,
    output emts_pkg::out_item_t         out_item,
    input  logic                        cfg_we,
    input  logic [emts_pkg::EPS_W-1:0]  cfg_data
);
    import emts_pkg::*;

    logic [EPS_W-1:0]   eps_reg;
    logic               en;
    logic               f_valid, d_valid, r_valid, d_neg;
    logic signed [65:0] f_numer;
    logic signed [41:0] f_denom;
    status_t            f_status, d_status;
    logic [64:0]        d_quot;
    out_item_t          r_item;
    logic               o_valid_reg;
    out_item_t          o_item_reg;

    // pipeline moves whenever the output register can take a result
    assign en       = !o_valid_reg || !out_stall;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EPS_RESET;
        else if (cfg_we)
            eps_reg <= cfg_data;
    end

    emts_front u_front (
        .clk, .rst_n, .en,
        .valid(in_valid && en), .item(in_item),
        .valid_out(f_valid), .numer(f_numer), .denom(f_denom), .pre_status(f_status)
    );

    emts_div u_div (
        .clk, .rst_n, .en,
        .valid(f_valid), .numer(f_numer), .denom(f_denom), .status_in(f_status),
        .valid_out(d_valid), .neg_out(d_neg), .quot(d_quot), .status_out(d_status)
    );

    emts_root #(.FRAC_BITS(FRAC_BITS)) u_root (
        .clk, .rst_n, .en,
        .valid(d_valid), .neg(d_neg), .quot(d_quot), .status_in(d_status),
        .clamp_epsilon(eps_reg),
        .valid_out(r_valid), .result(r_item)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (en)
            o_valid_reg <= r_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            o_item_reg <= r_item;
    end

    assign out_valid = o_valid_reg;
    assign out_item  = o_item_reg;

    // a held result stays put while the far side stalls
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && out_stall |=> o_valid_reg && $stable(o_item_reg))
        else $error("held result changed");

    // errors other than saturation give zero move
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && o_item_reg.status != ST_OK && o_item_reg.status != ST_SAT
        |-> o_item_reg.event_move == 32'd0)
        else $error("nonzero move on error");

    // input stall only when output is full and stalled
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> o_valid_reg && out_stall)
        else $error("spurious input stall");
endmodule

[rtl/emts_front.sv]
// front end: checks, numerator and denominator products
module emts_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid,
    input  emts_pkg::in_item_t   item,
    output logic                 valid_out,
    output logic signed [65:0]   numer,
    output logic signed [41:0]   denom,
    output emts_pkg::status_t    pre_status
);
    import emts_pkg::*;

    // stage a: four products, stage b: differences
    logic                a_valid_reg;
    logic signed [63:0]  a_w1t2_reg, a_w2t1_reg;
    logic signed [40:0]  a_n1t2_reg, a_n2t1_reg;
    status_t             a_status_reg, a_status_next;
    logic                b_valid_reg;
    logic signed [65:0]  b_numer_reg;
    logic signed [41:0]  b_denom_reg;
    status_t             b_status_reg;

    always_comb
    begin
        if (item.time_one <= 0 || item.time_two <= 0)
            a_status_next = ST_BAD_T;
        else if (item.time_one == item.time_two)
            a_status_next = ST_EQUAL_T;
        else
            a_status_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_w1t2_reg   <= 64'(item.variance_one * item.time_two);
            a_w2t1_reg   <= 64'(item.variance_two * item.time_one);
            a_n1t2_reg   <= 41'($signed({1'b0, item.count_one}) * item.time_two);
            a_n2t1_reg   <= 41'($signed({1'b0, item.count_two}) * item.time_one);
            a_status_reg <= a_status_next;
            b_numer_reg  <= 66'(a_w1t2_reg) - 66'(a_w2t1_reg);
            b_denom_reg  <= 42'(a_n1t2_reg) - 42'(a_n2t1_reg);
            b_status_reg <= (a_status_reg == ST_OK && a_n1t2_reg == a_n2t1_reg)
                            ? ST_UNIDENT : a_status_reg;
        end
    end

    assign valid_out  = b_valid_reg;
    assign numer      = b_numer_reg;
    assign denom      = b_denom_reg;
    assign pre_status = b_status_reg;
endmodule

[rtl/emts_div.sv]
// pipelined restoring divider, one quotient bit per stage, truncating toward zero
module emts_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                valid,
    input  logic signed [65:0]  numer,
    input  logic signed [41:0]  denom,
    input  emts_pkg::status_t   status_in,
    output logic                valid_out,
    output logic                neg_out,
    output logic [64:0]         quot,
    output emts_pkg::status_t   status_out
);
    import emts_pkg::*;

    localparam int QW = 65;
    localparam int DW = 41;

    logic [QW:0]        v_reg;
    logic               sgn_reg [0:QW];
    status_t            st_reg  [0:QW];
    logic [DW-1:0]      d_reg   [0:QW];
    logic [DW:0]        r_reg   [0:QW];
    logic [QW-1:0]      q_reg   [0:QW];

    // stage 0 takes magnitudes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[QW-1:0], valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sgn_reg[0] <= numer[65] ^ denom[41];
            st_reg[0]  <= status_in;
            d_reg[0]   <= denom[41] ? DW'(-denom) : DW'(denom);
            r_reg[0]   <= '0;
            q_reg[0]   <= numer[65] ? QW'(-numer) : QW'(numer);
        end
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_step
        logic [DW+1:0] trial;
        logic [DW+1:0] shifted;
        assign shifted = {r_reg[i], q_reg[i][QW-1]};
        assign trial   = shifted - {2'b0, d_reg[i]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sgn_reg[i+1] <= sgn_reg[i];
                st_reg[i+1]  <= st_reg[i];
                d_reg[i+1]   <= d_reg[i];
                r_reg[i+1]   <= trial[DW+1] ? shifted[DW:0] : trial[DW:0];
                q_reg[i+1]   <= {q_reg[i][QW-2:0], ~trial[DW+1]};
            end
        end
    end

    assign valid_out  = v_reg[QW];
    assign neg_out    = sgn_reg[QW] && (q_reg[QW] != '0);
    assign quot       = q_reg[QW];
    assign status_out = st_reg[QW];
endmodule

[rtl/emts_root.sv]
// range checks and pipelined integer square root, one result bit per stage
module emts_root #(
    parameter int FRAC_BITS = emts_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            valid,
    input  logic                            neg,
    input  logic [64:0]                     quot,
    input  emts_pkg::status_t               status_in,
    input  logic [emts_pkg::EPS_W-1:0]      clamp_epsilon,
    output logic                            valid_out,
    output emts_pkg::out_item_t             result
);
    import emts_pkg::*;

    localparam int RW = 32 + FRAC_BITS;   // radicand width, before rounding up to an even count
    localparam int RWE = RW + (RW % 2);
    localparam int SN = RWE / 2;          // root bits

    logic               c_valid_reg;
    logic [30:0]        c_esq_reg;
    status_t            c_status_reg, c_status_next;
    logic [30:0]        c_esq_next;

    always_comb
    begin
        c_status_next = status_in;
        c_esq_next    = '0;
        if (status_in == ST_OK)
        begin
            if (neg)
            begin
                if (quot > 65'(clamp_epsilon))
                    c_status_next = ST_NEG;
            end
            else if (quot > 65'h7FFF_FFFF)
            begin
                c_status_next = ST_SAT;
                c_esq_next    = '1;
            end
            else
                c_esq_next = quot[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_esq_reg    <= c_esq_next;
            c_status_reg <= c_status_next;
        end
    end

    logic [SN:0]    v_reg;
    status_t        st_reg [0:SN];
    logic [RWE-1:0] x_reg  [0:SN];
    logic [SN+1:0]  r_reg  [0:SN];
    logic [SN-1:0]  q_reg  [0:SN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[SN-1:0], c_valid_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= c_status_reg;
            x_reg[0]  <= RWE'({c_esq_reg, FRAC_BITS'(0)});
            r_reg[0]  <= '0;
            q_reg[0]  <= '0;
        end
    end

    for (genvar i = 0; i < SN; i++)
    begin : g_step
        logic [SN+1:0] rem_sh;
        logic [SN+1:0] trial;
        assign rem_sh = {r_reg[i][SN-1:0], x_reg[i][RWE-1 -: 2]};
        assign trial  = rem_sh - {q_reg[i], 2'b01};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[i+1] <= st_reg[i];
                x_reg[i+1]  <= x_reg[i] << 2;
                r_reg[i+1]  <= trial[SN+1] ? rem_sh : trial;
                q_reg[i+1]  <= {q_reg[i][SN-2:0], ~trial[SN+1]};
            end
        end
    end

    assign valid_out = v_reg[SN];
    always_comb
    begin
        result.status     = st_reg[SN];
        result.event_move = (st_reg[SN] == ST_OK || st_reg[SN] == ST_SAT)
                            ? 32'(q_reg[SN]) : 32'd0;
    end
endmodule
